### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked with an async active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// invariant on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

`endif

### sv/mbrx_pkg.sv
// ---------------------------------------------------------------------------
// mbrx_pkg
// shared types and codes of the modbus rtu response receiver
// ---------------------------------------------------------------------------
`default_nettype none

package mbrx_pkg;

	// item opcodes
	localparam logic [1:0] OP_ARM  = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// result status codes
	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_RECV    = 3'd1;
	localparam logic [2:0] ST_OK      = 3'd2;
	localparam logic [2:0] ST_EXC     = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_CRC     = 3'd5;

	// register map
	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_FUNCTION = 2'd0;
	localparam logic [1:0] REG_QUANTITY = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	localparam logic [7:0]  FUNCTION_RST = 8'd3;
	localparam logic [6:0]  QUANTITY_RST = 7'd1;
	localparam logic [15:0] TIMEOUT_RST  = 16'd1000;

	typedef struct packed {
		logic [7:0]  expected_function;
		logic [6:0]  expected_quantity;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic [6:0] byte_index;
		logic [7:0] exception_code;
		logic [6:0] frame_length;
	} result_t;

endpackage

`default_nettype wire

### sv/mbrx_if.sv
// ---------------------------------------------------------------------------
// mbrx_if
// valid/ready channels carrying items in and results out
// ---------------------------------------------------------------------------
`default_nettype none

interface mbrx_item_if;
	logic            valid;
	logic            ready;
	mbrx_pkg::item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mbrx_result_if;
	logic              valid;
	logic              ready;
	mbrx_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/modbus_rtu_response_receiver_top.sv
// ---------------------------------------------------------------------------
// modbus_rtu_response_receiver_top
// modbus rtu master receive side: framing, crc-16 check, exception, timeout
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  -------  ---  -------------  ----------------------------------------------
//  item     in   valid/ready    opcode, rx_byte
//  result   out  valid/ready    status, byte_valid, byte_value, byte_index,
//                               exception_code, frame_length
//  apb      in   psel/penable   expected_function, expected_quantity,
//                               timeout_ticks
//
//  one item per cycle sustained while results are taken; every item yields exactly one result
//  an item passes the input register, then the frame update and the result register
//  the frame update (crc byte fold plus length compare) is the one path per item
//  a stalled result keeps the result register full; the input register still
//  takes one item, then item.ready drops until the result moves on
//  arst_n resets the handshake valids, frame state and config registers at once
// ---------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_receiver_top #(
	parameter int MAX_FRAME = 127
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	mbrx_item_if.sink                        item,
	mbrx_result_if.source                    result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mbrx_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	mbrx_pkg::cfg_t    cfg;
	mbrx_pkg::item_t   item_s1;
	mbrx_pkg::result_t result_s2;
	mbrx_pkg::result_t engine_result;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	// configuration registers
	mbrx_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the held item moves into the frame logic when the result slot is free
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	// frame state and per-item result logic
	mbrx_engine #(
		.MAX_FRAME (MAX_FRAME)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (engine_result)
	);

	// result register, holds a transaction until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= engine_result;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = result_s2;

endmodule

`default_nettype wire

### sv/mbrx_apb_regs.sv
// ---------------------------------------------------------------------------
// mbrx_apb_regs
// apb register file: function code, quantity, timeout
// ---------------------------------------------------------------------------
`default_nettype none

module mbrx_apb_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mbrx_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output mbrx_pkg::cfg_t                   cfg
);

	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.expected_function <= mbrx_pkg::FUNCTION_RST;
			cfg.expected_quantity <= mbrx_pkg::QUANTITY_RST;
			cfg.timeout_ticks     <= mbrx_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			case (reg_sel)
				mbrx_pkg::REG_FUNCTION: cfg.expected_function <= pwdata[7:0];
				mbrx_pkg::REG_QUANTITY: cfg.expected_quantity <= pwdata[6:0];
				mbrx_pkg::REG_TIMEOUT:  cfg.timeout_ticks     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			mbrx_pkg::REG_FUNCTION: prdata = {24'd0, cfg.expected_function};
			mbrx_pkg::REG_QUANTITY: prdata = {25'd0, cfg.expected_quantity};
			mbrx_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg.timeout_ticks};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

### sv/mbrx_engine.sv
// ---------------------------------------------------------------------------
// mbrx_engine
// frame state, crc fold and completion check, one item per step
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mbrx_engine #(
	parameter int MAX_FRAME = 127
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire mbrx_pkg::item_t   item,
	input  wire mbrx_pkg::cfg_t    cfg,
	output mbrx_pkg::result_t      result
);

	localparam int LEN_CAP = (MAX_FRAME < 127) ? MAX_FRAME : 127;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_RECV = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [6:0]  bytes_received_q, bytes_received_n;
	logic [15:0] running_crc_q, running_crc_n;
	logic [15:0] frame_crc_q, frame_crc_n;
	logic [15:0] elapsed_ticks_q, elapsed_ticks_n;
	logic [7:0]  function_byte_q, function_byte_n;
	logic [7:0]  crc_low_byte_q, crc_low_byte_n;
	logic [2:0]  final_status_q, final_status_n;
	logic [7:0]  held_exception_q, held_exception_n;

	logic [8:0]  len_raw;
	logic [6:0]  len;
	logic [7:0]  count_wide;
	logic [6:0]  count;
	logic [16:0] tick_sum;
	logic        byte_valid;
	logic        crc_good;

	// one byte through the reflected crc-16, eight shift steps
	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	// expected response length from the function code
	always_comb begin
		case (cfg.expected_function) inside
			8'd1, 8'd2: len_raw = 9'd5 + {2'b00, cfg.expected_quantity};
			8'd3, 8'd4: len_raw = 9'd5 + {1'b0, cfg.expected_quantity, 1'b0};
			8'd5:       len_raw = 9'd7;
			8'd6, 8'd16: len_raw = 9'd8;
			default:    len_raw = 9'd0;
		endcase
		len = (len_raw > 9'(LEN_CAP)) ? 7'(LEN_CAP) : len_raw[6:0];
	end

	assign count_wide = {1'b0, bytes_received_q} + 8'd1;
	assign count      = (count_wide > 8'(LEN_CAP)) ? 7'(LEN_CAP) : count_wide[6:0];
	assign tick_sum   = {1'b0, elapsed_ticks_q} + 17'd1;

	always_comb begin
		phase_n          = phase_q;
		bytes_received_n = bytes_received_q;
		running_crc_n    = running_crc_q;
		frame_crc_n      = frame_crc_q;
		elapsed_ticks_n  = elapsed_ticks_q;
		function_byte_n  = function_byte_q;
		crc_low_byte_n   = crc_low_byte_q;
		final_status_n   = final_status_q;
		held_exception_n = held_exception_q;
		byte_valid       = 1'b0;
		crc_good         = 1'b0;

		case (item.opcode)
			mbrx_pkg::OP_ARM: begin
				phase_n          = PH_RECV;
				bytes_received_n = 7'd0;
				running_crc_n    = 16'hFFFF;
				frame_crc_n      = 16'hFFFF;
				elapsed_ticks_n  = 16'd0;
				function_byte_n  = 8'd0;
				crc_low_byte_n   = 8'd0;
				final_status_n   = mbrx_pkg::ST_RECV;
				held_exception_n = 8'd0;
			end
			mbrx_pkg::OP_BYTE: begin
				if (phase_q == PH_RECV) begin
					byte_valid = 1'b1;
					if (bytes_received_q == 7'd1)
						function_byte_n = item.rx_byte;
					if (bytes_received_q == 7'd2)
						held_exception_n = item.rx_byte;
					// capture crc over the body when the low crc byte arrives
					if (len >= 7'd2 && bytes_received_q == len - 7'd2) begin
						frame_crc_n    = running_crc_q;
						crc_low_byte_n = item.rx_byte;
					end
					running_crc_n    = crc_fold(running_crc_q, item.rx_byte);
					bytes_received_n = count;
					crc_good = (frame_crc_n[7:0] == crc_low_byte_n) &&
						(frame_crc_n[15:8] == item.rx_byte);
					if (count == 7'd5 && function_byte_n[7]) begin
						phase_n        = PH_DONE;
						final_status_n = mbrx_pkg::ST_EXC;
					end else if (len != 7'd0 && count == len &&
						bytes_received_q == len - 7'd1) begin
						phase_n        = PH_DONE;
						final_status_n = crc_good ? mbrx_pkg::ST_OK : mbrx_pkg::ST_CRC;
					end
				end
			end
			mbrx_pkg::OP_TICK: begin
				if (phase_q == PH_RECV) begin
					elapsed_ticks_n = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];
					if (tick_sum > {1'b0, cfg.timeout_ticks}) begin
						phase_n        = PH_DONE;
						final_status_n = mbrx_pkg::ST_TIMEOUT;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			bytes_received_q <= 7'd0;
			running_crc_q    <= 16'hFFFF;
			frame_crc_q      <= 16'hFFFF;
			elapsed_ticks_q  <= 16'd0;
			function_byte_q  <= 8'd0;
			crc_low_byte_q   <= 8'd0;
			final_status_q   <= mbrx_pkg::ST_IDLE;
			held_exception_q <= 8'd0;
		end else if (step) begin
			phase_q          <= phase_n;
			bytes_received_q <= bytes_received_n;
			running_crc_q    <= running_crc_n;
			frame_crc_q      <= frame_crc_n;
			elapsed_ticks_q  <= elapsed_ticks_n;
			function_byte_q  <= function_byte_n;
			crc_low_byte_q   <= crc_low_byte_n;
			final_status_q   <= final_status_n;
			held_exception_q <= held_exception_n;
		end
	end

	always_comb begin
		result.status         = final_status_n;
		result.byte_valid     = byte_valid;
		result.byte_value     = byte_valid ? item.rx_byte : 8'd0;
		result.byte_index     = byte_valid ? bytes_received_q : 7'd0;
		result.exception_code = (final_status_n == mbrx_pkg::ST_EXC) ? held_exception_n : 8'd0;
		result.frame_length   = len;
	end

	`ASSERT_ALWAYS(a_count_capped, clk, arst_n, bytes_received_q <= 7'(LEN_CAP), "byte count above cap")
	`ASSERT_SAME(a_done_final, clk, arst_n, phase_q == PH_DONE, final_status_q == mbrx_pkg::ST_OK || final_status_q == mbrx_pkg::ST_EXC || final_status_q == mbrx_pkg::ST_TIMEOUT || final_status_q == mbrx_pkg::ST_CRC, "done without final status")
	`ASSERT_SAME(a_recv_status, clk, arst_n, phase_q == PH_RECV, final_status_q == mbrx_pkg::ST_RECV, "receiving with wrong status")
	`ASSERT_NEXT(a_byte_counts, clk, arst_n, step && byte_valid, bytes_received_q != 7'd0, "accepted byte not counted")

endmodule

`default_nettype wire

### tb/modbus_rtu_response_receiver_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus_rtu_response_receiver_top_test
// self-checking bench for the modbus rtu response receiver: items go in over
// the item channel, a scoreboard predicts each result from its own copy of the
// frame state and registers, and results are checked in order as they leave
// ---------------------------------------------------------------------------

module modbus_rtu_response_receiver_top_test;
	import mbrx_pkg::*;

	localparam int FRAME_CAP = 127;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned RANDOM_ITEMS = 1650;
	localparam int unsigned HOLD_AT_RESULT = 300;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned TICK_OUT_MAX = 300;

	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [7:0]  EXC_FLAG = 8'h80;

	// function codes of the request side
	localparam logic [7:0] FN_READ_COILS    = 8'd1;
	localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FN_READ_INPUT    = 8'd4;
	localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FN_WRITE_REG     = 8'd6;
	localparam logic [7:0] FN_WRITE_MULTI   = 8'd16;
	localparam logic [7:0] FN_UNKNOWN       = 8'hFF;

	typedef enum logic [1:0] {FR_IDLE, FR_RECV, FR_DONE} frame_phase_e;

	// predicts one result per accepted item and checks results in order
	class rtu_response_scoreboard;
		cfg_t         regs;
		frame_phase_e fr_phase;
		logic [6:0]   rx_count;
		logic [15:0]  crc_acc;
		logic [15:0]  crc_at_tail;
		logic [15:0]  tick_count;
		logic [7:0]   fn_seen;
		logic [7:0]   crc_lo_seen;
		logic [7:0]   exc_seen;
		logic [2:0]   frame_status;
		result_t      awaited[$];
		int unsigned  failures;
		int unsigned  reports;

		function new();
			regs.expected_function = FUNCTION_RST;
			regs.expected_quantity = QUANTITY_RST;
			regs.timeout_ticks = TIMEOUT_RST;
			fr_phase = FR_IDLE;
			rx_count = '0;
			crc_acc = CRC_INIT;
			crc_at_tail = CRC_INIT;
			tick_count = '0;
			fn_seen = '0;
			crc_lo_seen = '0;
			exc_seen = '0;
			frame_status = ST_IDLE;
			failures = 0;
			reports = 0;
		endfunction

		static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
			crc = crc ^ {8'h00, b};
			for (int k = 0; k < 8; k++)
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			return crc;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_FUNCTION: regs.expected_function = value[7:0];
				REG_QUANTITY: regs.expected_quantity = value[6:0];
				REG_TIMEOUT:  regs.timeout_ticks = value[15:0];
				default: ;
			endcase
		endfunction

		function int unsigned resp_length();
			int unsigned n;
			case (regs.expected_function)
				FN_READ_COILS, FN_READ_DISCRETE: n = 5 + regs.expected_quantity;
				FN_READ_HOLDING, FN_READ_INPUT:  n = 5 + 2 * regs.expected_quantity;
				FN_WRITE_COIL:                   n = 7;
				FN_WRITE_REG, FN_WRITE_MULTI:    n = 8;
				default:                         n = 0;
			endcase
			return (n > FRAME_CAP) ? FRAME_CAP : n;
		endfunction

		function bit receiving();
			return fr_phase == FR_RECV;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		function void end_frame(logic [2:0] st);
			frame_status = st;
			fr_phase = FR_DONE;
		endfunction

		// returns 1 when the item did something beyond being ignored
		function bit accept_item(item_t it);
			result_t     r;
			int unsigned len;
			int unsigned pos;
			int unsigned cnt;
			logic [16:0] t;
			bit          active;
			len = resp_length();
			r = '0;
			active = 1'b0;
			if (it.opcode == OP_ARM) begin
				fr_phase = FR_RECV;
				rx_count = '0;
				crc_acc = CRC_INIT;
				crc_at_tail = CRC_INIT;
				tick_count = '0;
				fn_seen = '0;
				crc_lo_seen = '0;
				exc_seen = '0;
				frame_status = ST_RECV;
				active = 1'b1;
			end else if (it.opcode == OP_BYTE && fr_phase == FR_RECV) begin
				active = 1'b1;
				pos = rx_count;
				r.byte_valid = 1'b1;
				r.byte_value = it.rx_byte;
				r.byte_index = rx_count;
				if (pos == 1)
					fn_seen = it.rx_byte;
				if (pos == 2)
					exc_seen = it.rx_byte;
				if (len >= 2 && pos == len - 2) begin
					crc_at_tail = crc_acc;
					crc_lo_seen = it.rx_byte;
				end
				crc_acc = crc16_step(crc_acc, it.rx_byte);
				cnt = (pos + 1 > FRAME_CAP) ? FRAME_CAP : pos + 1;
				rx_count = cnt[6:0];
				if (cnt == 5 && fn_seen >= EXC_FLAG) begin
					end_frame(ST_EXC);
				end else if (len != 0 && cnt == len && pos == len - 1) begin
					end_frame((crc_at_tail == {it.rx_byte, crc_lo_seen}) ? ST_OK : ST_CRC);
				end
			end else if (it.opcode == OP_TICK && fr_phase == FR_RECV) begin
				active = 1'b1;
				t = {1'b0, tick_count} + 17'd1;
				tick_count = t[16] ? 16'hFFFF : t[15:0];
				if (t > {1'b0, regs.timeout_ticks})
					end_frame(ST_TIMEOUT);
			end
			r.status = frame_status;
			r.exception_code = (frame_status == ST_EXC) ? exc_seen : 8'h00;
			r.frame_length = len[6:0];
			awaited.push_back(r);
			return active;
		endfunction

		function void check_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				failures++;
				if (reports < 50) begin
					reports++;
					$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				end
			end
		endfunction

		function void compare_response(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				failures++;
				$display("%0t: result with nothing expected, expected none, actual %h", $time, got);
				return;
			end
			want = awaited.pop_front();
			check_field("status", want.status, got.status);
			check_field("byte_valid", want.byte_valid, got.byte_valid);
			check_field("byte_value", want.byte_value, got.byte_value);
			check_field("byte_index", want.byte_index, got.byte_index);
			check_field("exception_code", want.exception_code, got.exception_code);
			check_field("frame_length", want.frame_length, got.frame_length);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	mbrx_item_if   item_ch();
	mbrx_result_if result_ch();

	rtu_response_scoreboard sb = new();

	// shared idling switch: off gives back-to-back stretches on both sides
	bit          idle_on = 1'b1;
	int unsigned counted_items = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;

	modbus_rtu_response_receiver_top #(
		.MAX_FRAME(FRAME_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// one item transaction: optional gap with valid low, then hold until taken
	task automatic send_item(logic [1:0] op, logic [7:0] b);
		item_t       it;
		int unsigned gap;
		it.opcode = op;
		it.rx_byte = b;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		if (sb.accept_item(it))
			counted_items++;
	endtask

	task automatic send_bytes(int unsigned n);
		repeat (n) send_item(OP_BYTE, $urandom_range(0, 255));
	endtask

	// keep ticking until the frame ends, normally by timeout
	task automatic tick_until_done();
		while (sb.receiving()) send_item(OP_TICK, $urandom_range(0, 255));
	endtask

	// body bytes followed by their crc, low byte first, one bit flipped on request
	task automatic send_with_crc(logic [7:0] body[$], bit corrupt);
		logic [15:0] crc;
		crc = CRC_INIT;
		foreach (body[i]) crc = rtu_response_scoreboard::crc16_step(crc, body[i]);
		if (corrupt)
			crc = crc ^ (16'd1 << $urandom_range(0, 15));
		foreach (body[i]) send_item(OP_BYTE, body[i]);
		send_item(OP_BYTE, crc[7:0]);
		send_item(OP_BYTE, crc[15:8]);
	endtask

	// stop offering and wait until every expected result has left the block
	task automatic idle_and_drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup cycle, then access cycle until pready
	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		sb.write_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [7:0] fn, logic [6:0] qty, logic [15:0] tmo);
		idle_and_drain();
		apb_write(REG_FUNCTION, {24'd0, fn});
		apb_write(REG_QUANTITY, {25'd0, qty});
		apb_write(REG_TIMEOUT, {16'd0, tmo});
	endtask

	// mostly known function codes, small quantities and short timeouts
	task automatic random_config();
		logic [7:0]  fn;
		logic [6:0]  qty;
		logic [15:0] tmo;
		case ($urandom_range(0, 9))
			0: fn = FN_READ_COILS;
			1: fn = FN_READ_DISCRETE;
			2, 3: fn = FN_READ_HOLDING;
			4: fn = FN_READ_INPUT;
			5: fn = FN_WRITE_COIL;
			6: fn = FN_WRITE_REG;
			7: fn = FN_WRITE_MULTI;
			default: fn = $urandom_range(0, 255);
		endcase
		qty = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 6);
		tmo = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 60) : $urandom_range(61, 65534);
		configure(fn, qty, tmo);
	endtask

	// one response: well-formed or with a bad crc, the rest exceptions, timeouts,
	// cut-off frames and noise
	task automatic random_frame(bit do_arm);
		logic [7:0]  body[$];
		int unsigned len;
		int unsigned kind;
		logic [7:0]  fn;
		len = sb.resp_length();
		kind = $urandom_range(0, 99);
		if (do_arm)
			send_item(OP_ARM, $urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_item(OP_TICK, $urandom_range(0, 255));
		fn = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : sb.regs.expected_function;
		if (kind < 60) begin
			if (len == 0) begin
				// unknown function: no length end, a timeout or exception code ends it, sometimes past the cap
				send_bytes(($urandom_range(0, 7) == 0) ? 130 : $urandom_range(3, 12));
				if (sb.regs.timeout_ticks <= TICK_OUT_MAX)
					tick_until_done();
			end else begin
				body.push_back($urandom_range(0, 255));
				body.push_back(fn);
				repeat (len - 4) body.push_back($urandom_range(0, 255));
				send_with_crc(body, kind >= 45);
			end
		end else if (kind < 72) begin
			send_item(OP_BYTE, $urandom_range(0, 255));
			send_item(OP_BYTE, $urandom_range(128, 255));
			send_bytes(3);
			send_bytes($urandom_range(0, 2));
		end else if (kind < 82) begin
			send_bytes($urandom_range(0, 3));
			if (sb.regs.timeout_ticks <= TICK_OUT_MAX)
				tick_until_done();
			else
				repeat ($urandom_range(1, 5)) send_item(OP_TICK, $urandom_range(0, 255));
		end else if (kind < 90) begin
			// cut short, the next arm restarts it
			send_bytes($urandom_range(1, 6));
		end else begin
			repeat ($urandom_range(1, 6))
				send_item($urandom_range(0, 3), $urandom_range(0, 255));
		end
	endtask

	// result side: random stalls, one long hold-off so the block backs up
	initial begin
		int unsigned stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == HOLD_AT_RESULT)
				stall = HOLD_CYCLES;
			else
				stall = idle_on ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (result_ch.valid !== 1'b1) @(posedge clk);
			sb.compare_response(result_ch.payload);
			results_seen++;
		end
	end

	// main sequence
	initial begin
		logic [7:0]  body[$];
		int unsigned phase_no;
		int unsigned frames;
		bit          first_arm;

		// every input known from time zero, reset held low before release
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: register defaults give a 7 byte holding-register response
		// bytes and ticks while idle are ignored
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_ARM, 8'h00);
		body = '{8'h11, FN_READ_HOLDING, 8'h02, 8'h00, 8'hFF};
		send_with_crc(body, 1'b0);
		// after completion: a late byte and the unused opcode are ignored
		send_item(OP_BYTE, 8'hA5);
		send_item(OP_SPARE, 8'h5A);
		// exception response ends at five bytes, code taken from byte two
		send_item(OP_ARM, 8'hFF);
		send_item(OP_BYTE, 8'h11);
		send_item(OP_BYTE, 8'h83);
		send_item(OP_BYTE, 8'h02);
		send_bytes(2);
		// corrupted crc
		send_item(OP_ARM, 8'h00);
		body = '{8'h01, FN_READ_HOLDING, 8'h02, 8'h12, 8'h34};
		send_with_crc(body, 1'b1);

		// random phases, each with its own register setting
		counted_items = 0;
		phase_no = 0;
		while (counted_items < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			case (phase_no)
				0: configure(FN_READ_HOLDING, 7'd125, 16'hFFFF);
				1: begin
					// length cap: index sticks at the cap, then a timeout set to one tick
					configure(FN_UNKNOWN, 7'd0, 16'd1);
					send_item(OP_ARM, 8'h00);
					send_bytes(130);
					tick_until_done();
				end
				2: begin
					// five byte response where exception and length coincide
					configure(FN_READ_COILS, 7'd0, 16'd1);
					send_item(OP_ARM, 8'h00);
					send_item(OP_BYTE, 8'h07);
					send_item(OP_BYTE, 8'h81);
					send_item(OP_BYTE, 8'h04);
					send_bytes(2);
				end
				3: configure(8'h00, 7'd125, 16'd40);
				default: random_config();
			endcase
			frames = (phase_no == 0) ? 2 : $urandom_range(3, 12);
			// sometimes carry on with a frame armed under the old setting
			first_arm = ($urandom_range(0, 3) != 0);
			for (int f = 0; f < frames; f++)
				random_frame(f != 0 || first_arm);
			phase_no++;
		end

		idle_and_drain();
		if (sb.failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/mbrx_pkg.sv
sv/mbrx_if.sv
sv/mbrx_apb_regs.sv
sv/mbrx_engine.sv
sv/modbus_rtu_response_receiver_top.sv
tb/modbus_rtu_response_receiver_top_test.sv
